### hw/rtl/kcd_pkg.sv
// ----------------------------------------------------------------------------
// kcd_pkg: shared types and constants of the key click / long-press detector
// Key mask codes, event kinds, the queue entry format and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package kcd_pkg;

	localparam int KEY_W   = 3;
	localparam int KIND_W  = 3;
	localparam int LPT_W   = 10;
	localparam int DCT_W   = 8;
	localparam int CFG_W   = 10;
	localparam int CFG_IDX_W = 2;
	localparam int DATA_W  = 8;

	localparam int QUEUE_DEPTH_DEF = 2;

	// key mask: bit0 ball, bit1 A, bit2 B
	localparam logic [KEY_W-1:0] KEY_IDLE  = 3'd0;
	localparam logic [KEY_W-1:0] KEY_TRACK = 3'd1;
	localparam logic [KEY_W-1:0] KEY_A     = 3'd2;
	localparam logic [KEY_W-1:0] KEY_B     = 3'd4;
	localparam logic [KEY_W-1:0] KEY_AB    = 3'd6;
	localparam logic [KEY_W-1:0] KEY_ALL   = 3'd7;

	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK = 2'd1;

	localparam logic [LPT_W-1:0] LPT_RESET = 10'd100;
	localparam logic [DCT_W-1:0] DCT_RESET = 8'd10;

	typedef enum logic [KIND_W-1:0] {
		KIND_NONE   = 3'd0,
		KIND_HELD   = 3'd1,
		KIND_SINGLE = 3'd2,
		KIND_LONG   = 3'd3,
		KIND_DOUBLE = 3'd4
	} event_kind_t;

	// one classified tick travelling through the queue
	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
	} kcd_entry_t;

endpackage

`default_nettype wire

### hw/rtl/kcd_front.sv
// ----------------------------------------------------------------------------
// kcd_front: input side of the detector
// Accepts key flag samples and encodes them by priority into a key mask.
// ----------------------------------------------------------------------------
`default_nettype none

module kcd_front (
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [kcd_pkg::DATA_W-1:0] s_tdata,  // [0] ball, [1] touch A, [2] touch B
	input  wire logic                     q_ready,
	output kcd_pkg::kcd_entry_t           push
);
	import kcd_pkg::*;

	logic ball;
	logic key_a;
	logic key_b;
	logic [KEY_W-1:0] code;

	assign ball  = s_tdata[0];
	assign key_a = s_tdata[1];
	assign key_b = s_tdata[2];

	always_comb begin
		if (ball && key_a && key_b) begin
			code = KEY_ALL;
		end else if (key_a && key_b) begin
			code = KEY_AB;
		end else if (ball) begin
			code = KEY_TRACK;
		end else if (key_a) begin
			code = KEY_A;
		end else if (key_b) begin
			code = KEY_B;
		end else begin
			code = KEY_IDLE;
		end
	end

	assign s_tready   = q_ready;
	assign push.valid = s_tvalid && q_ready;
	assign push.key   = code;

endmodule

`default_nettype wire

### hw/rtl/kcd_queue.sv
// ----------------------------------------------------------------------------
// kcd_queue: short queue between the front and the back
// Holds classified ticks so either side may stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module kcd_queue #(
	parameter int DEPTH = kcd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire kcd_pkg::kcd_entry_t push,
	output logic                     push_ready,
	output kcd_pkg::kcd_entry_t      head,
	input  wire logic                pop
);
	import kcd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [KEY_W-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_FULL);
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.key   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("pop from empty queue");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with empty count");

endmodule

`default_nettype wire

### hw/rtl/kcd_back.sv
// ----------------------------------------------------------------------------
// kcd_back: event resolution of the detector
// Tracks hold and click state per tick and registers one event per tick.
// ----------------------------------------------------------------------------
`default_nettype none

module kcd_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire kcd_pkg::kcd_entry_t           head,
	output logic                               pop,
	input  wire logic                          cfg_we,
	input  wire logic [kcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [kcd_pkg::CFG_W-1:0]     cfg_wdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [kcd_pkg::DATA_W-1:0]         m_tdata  // [2:0] key_code, [5:3] event_kind
);
	import kcd_pkg::*;

	logic [LPT_W-1:0] long_ticks_q;
	logic [DCT_W-1:0] double_ticks_q;

	logic [KEY_W-1:0] prev_key_q;
	logic [KEY_W-1:0] hold_cand_q;
	logic [KEY_W-1:0] click_cand_q;
	logic [LPT_W-1:0] hold_cnt_q;
	logic [DCT_W-1:0] idle_cnt_q;
	logic             click_pend_q;

	logic [KEY_W-1:0] hold_cand_d;
	logic [KEY_W-1:0] click_cand_d;
	logic [LPT_W-1:0] hold_cnt_d;
	logic [DCT_W-1:0] idle_cnt_d;
	logic             click_pend_d;

	logic [KEY_W-1:0] key;
	logic [KEY_W-1:0] pressed;
	logic [KEY_W-1:0] ev_key;
	event_kind_t      ev_kind;

	logic             out_valid_q;
	logic [KEY_W-1:0] out_key_q;
	event_kind_t      out_kind_q;

	assign pop = head.valid && (!out_valid_q || m_tready);
	assign key = head.key;
	assign pressed = key & ~prev_key_q;

	always_comb begin
		hold_cand_d  = hold_cand_q;
		click_cand_d = click_cand_q;
		hold_cnt_d   = hold_cnt_q;
		idle_cnt_d   = idle_cnt_q;
		click_pend_d = click_pend_q;
		ev_key       = KEY_IDLE;
		ev_kind      = KIND_NONE;

		if (key == KEY_ALL || key == KEY_TRACK) begin
			// held report leaves the hold and click state alone
			ev_key  = key;
			ev_kind = KIND_HELD;
		end else begin
			if (key == hold_cand_q) begin
				if (hold_cnt_q != '1) begin
					hold_cnt_d = hold_cnt_q + LPT_W'(1);
				end
				if (hold_cnt_d >= long_ticks_q) begin
					if (key inside {KEY_A, KEY_B, KEY_AB}) begin
						ev_key  = key;
						ev_kind = KIND_LONG;
					end
					hold_cnt_d   = long_ticks_q;
					click_pend_d = 1'b0;
					click_cand_d = KEY_IDLE;
				end
			end else begin
				hold_cnt_d = '0;
			end

			if (pressed != KEY_IDLE) begin
				hold_cand_d = pressed;
			end

			if (click_cand_d != KEY_IDLE && click_pend_d) begin
				if (key == KEY_IDLE && idle_cnt_q != '1) begin
					idle_cnt_d = idle_cnt_q + DCT_W'(1);
				end
				if (idle_cnt_d < double_ticks_q && pressed == click_cand_d) begin
					if (click_cand_d inside {KEY_A, KEY_B}) begin
						ev_key  = click_cand_d;
						ev_kind = KIND_DOUBLE;
					end
					click_pend_d = 1'b0;
					idle_cnt_d   = '0;
				end else if (idle_cnt_d >= double_ticks_q) begin
					ev_key       = click_cand_d;
					ev_kind      = KIND_SINGLE;
					idle_cnt_d   = '0;
					click_pend_d = 1'b0;
				end
			end

			// a tick that already gave an event does not open a new click
			if (pressed != KEY_IDLE && ev_kind == KIND_NONE) begin
				click_cand_d = pressed;
				click_pend_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_ticks_q   <= LPT_RESET;
			double_ticks_q <= DCT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LONG_PRESS:   long_ticks_q   <= cfg_wdata[LPT_W-1:0];
				REG_DOUBLE_CLICK: double_ticks_q <= cfg_wdata[DCT_W-1:0];
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_key_q   <= KEY_IDLE;
			hold_cand_q  <= KEY_IDLE;
			click_cand_q <= KEY_IDLE;
			hold_cnt_q   <= '0;
			idle_cnt_q   <= '0;
			click_pend_q <= 1'b0;
		end else if (pop) begin
			prev_key_q   <= key;
			hold_cand_q  <= hold_cand_d;
			click_cand_q <= click_cand_d;
			hold_cnt_q   <= hold_cnt_d;
			idle_cnt_q   <= idle_cnt_d;
			click_pend_q <= click_pend_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_key_q  <= ev_key;
			out_kind_q <= ev_kind;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_kind_q, out_key_q};

	a_held_key: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == KIND_HELD) |->
			(out_key_q == KEY_TRACK || out_key_q == KEY_ALL))
		else $error("held report on a key other than ball or all");

	a_double_key: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == KIND_DOUBLE) |-> (out_key_q == KEY_A || out_key_q == KEY_B))
		else $error("double click on a key other than A or B");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == KIND_NONE) |-> (out_key_q == KEY_IDLE))
		else $error("empty event carries a key code");

	a_pop_fills: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q)
		else $error("popped tick did not reach the output register");

endmodule

`default_nettype wire

### hw/rtl/key_click_longpress_detector_core.sv
// ----------------------------------------------------------------------------
// key_click_longpress_detector_core: key click, double click and long press
// Front encodes key samples, a short queue decouples, back resolves events.
// ----------------------------------------------------------------------------
// Path: an input transfer enters the queue, then the back stage pops it into
// its output register. Throughput: one item per cycle while m_tready is high,
// set by the back stage state update; queue and output register let both sides stall.
// Reset: arst_n clears all detector state, empties the queue and loads the
// register defaults (long press 100 ticks, double click 10 ticks).
`default_nettype none

module key_click_longpress_detector_core #(
	parameter int QUEUE_DEPTH = kcd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [kcd_pkg::DATA_W-1:0]    s_tdata,  // [0] ball, [1] touch A, [2] touch B
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [kcd_pkg::DATA_W-1:0]         m_tdata,  // [2:0] key_code, [5:3] event_kind
	input  wire logic                          cfg_we,
	input  wire logic [kcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [kcd_pkg::CFG_W-1:0]     cfg_wdata
);
	import kcd_pkg::*;

	kcd_entry_t push;
	kcd_entry_t head;
	logic       q_ready;
	logic       pop;

	kcd_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_ready  (q_ready),
		.push     (push)
	);

	kcd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (q_ready),
		.head       (head),
		.pop        (pop)
	);

	kcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the key click / long-press detector core
// Feeds key samples as a stream, predicts the event of every tick in the bench
// and compares each result transfer; varies the timing registers and the
// idle and stall patterns on both sides of the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import kcd_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int LONG_STALL  = 80;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0] code;
		event_kind_t      kind;
	} key_event_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [DATA_W-1:0]    s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [DATA_W-1:0]    m_tdata;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	// bench copy of the registers and the detector state
	logic [LPT_W-1:0] press_limit  = LPT_RESET;
	logic [DCT_W-1:0] click_window = DCT_RESET;
	logic [KEY_W-1:0] last_key     = KEY_IDLE;
	logic [KEY_W-1:0] hold_key     = KEY_IDLE;
	logic [KEY_W-1:0] click_key    = KEY_IDLE;
	logic [LPT_W-1:0] hold_ticks   = '0;
	logic [DCT_W-1:0] idle_ticks   = '0;
	logic             click_armed  = 1'b0;

	logic [KEY_W-1:0] samples_q[$];
	key_event_t       events_q[$];

	int samples_left = 0;
	int queued       = 0;
	int idle_pct     = 0;
	int stall_pct    = 0;
	int rx_hold_left = 0;
	bit rx_long_req  = 0;
	int quiet        = 0;
	int mismatches   = 0;
	int ticks_sent   = 0;
	int settings     = 1;
	int n_held = 0, n_single = 0, n_long = 0, n_double = 0;

	key_click_longpress_detector_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),    // [0] ball, [1] touch A, [2] touch B
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),    // [2:0] key_code, [5:3] event_kind
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// advance the detector by one tick and return the event it gives
	function automatic key_event_t classify_tick(input logic [KEY_W-1:0] sample);
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] fresh;
		key_event_t       ev;
		if (sample[0] && sample[1] && sample[2])
			key = KEY_ALL;
		else if (sample[1] && sample[2])
			key = KEY_AB;
		else if (sample[0])
			key = KEY_TRACK;
		else if (sample[1])
			key = KEY_A;
		else if (sample[2])
			key = KEY_B;
		else
			key = KEY_IDLE;
		fresh = key & ~last_key;
		ev.code = KEY_IDLE;
		ev.kind = KIND_NONE;
		last_key = key;
		if (key == KEY_ALL || key == KEY_TRACK) begin
			ev.code = key;
			ev.kind = KIND_HELD;
			return ev;
		end
		if (key == hold_key) begin
			if (hold_ticks != 10'd1023)
				hold_ticks++;
			if (hold_ticks >= press_limit) begin
				if (key == KEY_A || key == KEY_B || key == KEY_AB) begin
					ev.code = key;
					ev.kind = KIND_LONG;
				end
				// long press reached: clamp the count and drop any pending click
				hold_ticks = press_limit;
				click_armed = 1'b0;
				click_key = KEY_IDLE;
			end
		end else
			hold_ticks = '0;
		if (fresh != KEY_IDLE)
			hold_key = fresh;
		if (click_key != KEY_IDLE && click_armed) begin
			if (key == KEY_IDLE && idle_ticks != 8'd255)
				idle_ticks++;
			if (idle_ticks < click_window && fresh == click_key) begin
				// a second press of A+B is dropped without an event
				if (click_key == KEY_A || click_key == KEY_B) begin
					ev.code = click_key;
					ev.kind = KIND_DOUBLE;
				end
				click_armed = 1'b0;
				idle_ticks = '0;
			end else if (idle_ticks >= click_window) begin
				ev.code = click_key;
				ev.kind = KIND_SINGLE;
				idle_ticks = '0;
				click_armed = 1'b0;
			end
		end
		if (fresh != KEY_IDLE && ev.kind == KIND_NONE) begin
			click_key = fresh;
			click_armed = 1'b1;
		end
		return ev;
	endfunction

	// sender: offer queued samples, predict at each input transfer
	always @(posedge clk) begin
		logic [KEY_W-1:0] next_sample;
		if (s_tvalid && s_tready) begin
			events_q.push_back(classify_tick(s_tdata[KEY_W-1:0]));
			samples_left--;
			ticks_sent++;
		end
		if (!s_tvalid || s_tready) begin
			if (samples_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				next_sample = samples_q.pop_front();
				s_tdata <= {{(DATA_W-KEY_W){1'b0}}, next_sample};
				s_tvalid <= 1'b1;
			end else
				s_tvalid <= 1'b0;
		end
	end

	// receiver: check each result transfer against the oldest prediction
	always @(posedge clk) begin
		key_event_t want;
		if (m_tvalid && m_tready) begin
			if (events_q.size() == 0) begin
				$error("result with no tick waiting: key_code %0d event_kind %0d",
					m_tdata[2:0], m_tdata[5:3]);
				mismatches++;
			end else begin
				want = events_q.pop_front();
				if (m_tdata[2:0] !== want.code) begin
					$error("key_code: expected %0d, got %0d", want.code, m_tdata[2:0]);
					mismatches++;
				end
				if (m_tdata[5:3] !== want.kind) begin
					$error("event_kind: expected %0d, got %0d", want.kind, m_tdata[5:3]);
					mismatches++;
				end
				case (want.kind)
					KIND_HELD:   n_held++;
					KIND_SINGLE: n_single++;
					KIND_LONG:   n_long++;
					KIND_DOUBLE: n_double++;
					default: ;
				endcase
			end
		end
		if (rx_hold_left != 0) begin
			rx_hold_left--;
			m_tready <= 1'b0;
		end else if (rx_long_req) begin
			// hold off long enough for the block to fill and stall its input
			rx_long_req = 0;
			rx_hold_left = LONG_STALL;
			m_tready <= 1'b0;
		end else
			m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet = 0;
		else
			quiet++;
		if (quiet == QUIET_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic queue_ticks(input logic [KEY_W-1:0] sample, input int n);
		repeat (n) begin
			samples_q.push_back(sample);
			samples_left++;
			queued++;
		end
	endtask

	task automatic wait_drained();
		while (samples_left != 0 || events_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_timing(input logic [LPT_W-1:0] lpt, input logic [DCT_W-1:0] dct);
		wait_drained();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_LONG_PRESS;
		cfg_wdata <= CFG_W'(lpt);
		@(posedge clk);
		cfg_index <= REG_DOUBLE_CLICK;
		cfg_wdata <= CFG_W'(dct);
		@(posedge clk);
		cfg_we <= 1'b0;
		press_limit = lpt;
		click_window = dct;
		settings++;
		queued = 0;
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(2))
			0:       return KEY_A;
			1:       return KEY_B;
			default: return KEY_AB;
		endcase
	endfunction

	// idle gap after a gesture: half up to the click window, half at it or just past it
	function automatic int gap_len();
		if ($urandom_range(1))
			return $urandom_range(click_window);
		return int'(click_window) + $urandom_range(2);
	endfunction

	task automatic add_gesture();
		logic [KEY_W-1:0] k;
		int               hold;
		k = pick_key();
		case ($urandom_range(9))
			0, 1, 2: begin
				queue_ticks(k, 1 + $urandom_range(2));
				queue_ticks(KEY_IDLE, gap_len());
			end
			3, 4: begin
				queue_ticks(k, 1 + $urandom_range(1));
				queue_ticks(KEY_IDLE, $urandom_range(click_window));
				queue_ticks(k, 1 + $urandom_range(1));
				queue_ticks(KEY_IDLE, gap_len());
			end
			5, 6: begin
				hold = int'(press_limit) + $urandom_range(3) - 1;
				if (hold < 1)
					hold = 1;
				queue_ticks(k, hold);
				queue_ticks(KEY_IDLE, gap_len());
			end
			7: begin
				queue_ticks(KEY_W'($urandom_range(7)) | KEY_TRACK, 1 + $urandom_range(3));
				queue_ticks(k, 1 + $urandom_range(2));
				queue_ticks(KEY_IDLE, gap_len());
			end
			8: begin
				repeat (1 + $urandom_range(5))
					queue_ticks(KEY_W'($urandom_range(7)), 1);
			end
			default: begin
				// roll from one key set to another without a release
				repeat (2 + $urandom_range(1))
					queue_ticks(pick_key(), 1 + $urandom_range(3));
				queue_ticks(KEY_IDLE, gap_len());
			end
		endcase
	endtask

	task automatic fill(input int budget);
		while (queued < budget)
			add_gesture();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_LONG_PRESS;
		cfg_wdata = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults after reset
		fill(150);

		// directed ticks: held reports, clicks, double clicks and a roll from A+B to A
		set_timing(10'd3, 8'd3);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_UNUSED;
		cfg_wdata <= CFG_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		queue_ticks(KEY_IDLE, 1);
		queue_ticks(KEY_TRACK, 1);
		queue_ticks(KEY_TRACK | KEY_A, 1);
		queue_ticks(KEY_TRACK | KEY_B, 1);
		queue_ticks(KEY_ALL, 1);
		queue_ticks(KEY_IDLE, 1);
		queue_ticks(KEY_A, 1);
		queue_ticks(KEY_IDLE, 3);
		queue_ticks(KEY_A, 1);
		queue_ticks(KEY_IDLE, 1);
		queue_ticks(KEY_A, 1);
		queue_ticks(KEY_IDLE, 1);
		queue_ticks(KEY_B, 1);
		queue_ticks(KEY_IDLE, 1);
		queue_ticks(KEY_B, 1);
		queue_ticks(KEY_IDLE, 1);
		queue_ticks(KEY_AB, 1);
		queue_ticks(KEY_IDLE, 1);
		queue_ticks(KEY_AB, 1);
		queue_ticks(KEY_A, 5);
		queue_ticks(KEY_IDLE, 1);

		set_timing(10'd1, 8'd1);
		idle_pct = 70;
		fill(120);

		set_timing(10'd250, 8'd1);
		idle_pct = 0;
		stall_pct = 70;
		queue_ticks(KEY_AB, 252);
		queue_ticks(KEY_IDLE, 2);

		set_timing(10'd5, 8'd255);
		idle_pct = 33;
		stall_pct = 33;
		queue_ticks(KEY_B, 1);
		queue_ticks(KEY_IDLE, 256);

		set_timing(10'd8, 8'd4);
		idle_pct = 0;
		stall_pct = 0;
		fill(150);
		rx_long_req = 1;

		// sender pauses midway until every result is back
		set_timing(10'd20, 8'd6);
		idle_pct = 70;
		fill(75);
		wait_drained();
		fill(150);

		set_timing(10'd2, 8'd2);
		idle_pct = 33;
		stall_pct = 33;
		fill(120);

		set_timing(LPT_W'($urandom_range(40, 1)), DCT_W'($urandom_range(12, 1)));
		idle_pct = 0;
		stall_pct = 70;
		fill(120);

		wait_drained();
		$display("%0d ticks under %0d register settings", ticks_sent, settings);
		$display("events seen: %0d held, %0d single, %0d double, %0d long press",
			n_held, n_single, n_double, n_long);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
hw/rtl/kcd_pkg.sv
hw/rtl/kcd_front.sv
hw/rtl/kcd_queue.sv
hw/rtl/kcd_back.sv
hw/rtl/key_click_longpress_detector_core.sv
bench/tb.sv
